FILE: hw/rtl/rnb_pkg.sv
// Package for the reoriented normal blend: widths, vector and side-band types,
// and the fixed-point rounding helper. No dependencies.
`timescale 1ns / 1ps
package rnb_pkg;

  localparam int CB  = 16;          // component bits
  localparam int FB  = 14;          // fraction bits
  localparam int MLW = 10;          // min length squared register width
  localparam int VW  = CB + 4;      // vector width into a normaliser
  localparam int SW  = 2 * VW + 2;  // sum of squares width
  localparam int XW  = 62;          // normalised square window
  localparam int RW  = XW / 2;      // square root bits
  localparam int KW  = 6;           // shift count width
  localparam int QB  = FB + 2;      // quotient bits
  localparam int NW  = FB + 33;     // dividend width
  localparam int AW  = FB + 1;      // clamped strength width
  localparam int PW  = 2 * CB + 8;  // product width
  localparam int ONE = 1 << FB;

  typedef logic signed [CB-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic signed [VW-1:0] ncomp_t;
  typedef ncomp_t [2:0] nvec_t;

  typedef struct packed {
    vec_t          base;
    logic [AW-1:0] amount;
  } side_t;

  // round x / 2^FB half away from zero
  function automatic logic signed [PW-1:0] drop_frac(input logic signed [PW-1:0] a);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = a[PW-1] ? PW'(-a) : PW'(a);
    r = (m + (PW'(1) << (FB - 1))) >> FB;
    return a[PW-1] ? $signed(-r) : $signed(r);
  endfunction

endpackage

FILE: hw/rtl/rnb_in_if.sv
// Input channel of the reoriented normal blend: valid/ready plus one item.
// Depends on rnb_pkg.
`timescale 1ns / 1ps
interface rnb_in_if import rnb_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t receiver_x;
  comp_t receiver_y;
  comp_t receiver_z;
  comp_t detail_x;
  comp_t detail_y;
  comp_t detail_z;
  comp_t strength;

  modport source (output valid, receiver_x, receiver_y, receiver_z,
                  detail_x, detail_y, detail_z, strength, input ready);
  modport sink (input valid, receiver_x, receiver_y, receiver_z,
                detail_x, detail_y, detail_z, strength, output ready);
endinterface

FILE: hw/rtl/rnb_out_if.sv
// Output channel of the reoriented normal blend: valid/ready plus one item.
// Depends on rnb_pkg.
`timescale 1ns / 1ps
interface rnb_out_if import rnb_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: hw/rtl/rnb_norm.sv
// Pipelined vector normaliser: sum of squares, even shift, digit square root,
// restoring divide per lane, fallback select. Depends on rnb_pkg.
`timescale 1ns / 1ps
module rnb_norm import rnb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  nvec_t          v_i,
  input  vec_t           fb_i,
  input  side_t          side_i,
  input  logic [MLW-1:0] mls_i,
  output logic           valid_o,
  output vec_t           n_o,
  output side_t          side_o
);

  localparam int SHN   = 5;
  localparam int P_SUM = 2;
  localparam int P_RT  = 3 + SHN;
  localparam int P_DS  = P_RT + RW;
  localparam int P_OUT = P_DS + 1 + QB;
  localparam int NS    = P_OUT + 1;
  localparam int RMW   = RW + 3;
  localparam int DW    = RW + 1;

  typedef struct packed {
    logic [2:0][VW-1:0] mag;
    logic [2:0]         neg;
    logic               fall;
    vec_t               fb;
    side_t              side;
  } ctx_t;

  ctx_t                ctx_d;
  ctx_t                ctx_q [P_OUT];
  logic [NS-1:0]       vld_q;
  logic [2*VW-1:0]     sq_q [3];
  logic [SW-1:0]       s_d;
  logic                fall_d;
  logic [XW-1:0]       x_q [SHN+1];
  logic [KW-1:0]       k_q [SHN+1];
  logic [XW-1:0]       xs_q [RW];
  logic [KW-1:0]       ks_q [RW];
  logic [RMW-1:0]      rem_q [RW];
  logic [RW-1:0]       root_q [RW];
  logic [NW-1:0]       num_d [3];
  logic [2:0][NW-1:0]  dn_q [QB+1];
  logic [2:0][QB-1:0]  dq_q [QB+1];
  logic [DW-1:0]       dd_q [QB+1];
  vec_t                n_q;
  side_t               side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_comb begin
    logic [VW-1:0] vu;
    ctx_d      = '0;
    ctx_d.fb   = fb_i;
    ctx_d.side = side_i;
    for (int i = 0; i < 3; i++) begin
      vu             = v_i[i];
      ctx_d.neg[i]   = vu[VW-1];
      ctx_d.mag[i]   = vu[VW-1] ? -vu : vu;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= ctx_d;
    end
  end

  for (genvar g = 1; g < P_OUT; g++) begin : g_ctx
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[g] <= ctx_q[g-1];
        if (g == P_SUM) begin
          ctx_q[g].fall <= fall_d;
        end
      end
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*VW)'(ctx_q[0].mag[i]) * (2*VW)'(ctx_q[0].mag[i]);
      end
    end
  end

  // sum and short test
  assign s_d    = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  assign fall_d = (s_d == '0) || ((s_d >> FB) <= SW'(mls_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= XW'(s_d);
      k_q[0] <= '0;
    end
  end

  // even shift into [2^60, 2^62)
  for (genvar j = 1; j <= SHN; j++) begin : g_sh
    localparam int STEP = 2 << (SHN - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((x_q[j-1] >> (XW - STEP)) == '0) begin
          x_q[j] <= x_q[j-1] << STEP;
          k_q[j] <= k_q[j-1] + KW'(STEP);
        end else begin
          x_q[j] <= x_q[j-1];
          k_q[j] <= k_q[j-1];
        end
      end
    end
  end

  // square root, one result bit a stage
  for (genvar r = 0; r < RW; r++) begin : g_rt
    logic [XW-1:0]  xin;
    logic [KW-1:0]  kin;
    logic [RMW-1:0] rin;
    logic [RW-1:0]  qin;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    if (r == 0) begin : g_first
      assign xin = x_q[SHN];
      assign kin = k_q[SHN];
      assign rin = '0;
      assign qin = '0;
    end else begin : g_next
      assign xin = xs_q[r-1];
      assign kin = ks_q[r-1];
      assign rin = rem_q[r-1];
      assign qin = root_q[r-1];
    end
    assign cur   = {rin[RMW-3:0], xin[XW-1 -: 2]};
    assign trial = RMW'({qin, 2'b01});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xs_q[r] <= xin << 2;
        ks_q[r] <= kin;
        if (cur >= trial) begin
          rem_q[r]  <= cur - trial;
          root_q[r] <= {qin[RW-2:0], 1'b1};
        end else begin
          rem_q[r]  <= cur;
          root_q[r] <= {qin[RW-2:0], 1'b0};
        end
      end
    end
  end

  // divide set-up: N = 2*num + L, D = 2*L
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NW'(ctx_q[P_DS-1].mag[i]) << ks_q[RW-1][KW-1:1]) << FB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dn_q[0][i] <= (num_d[i] << 1) + NW'(root_q[RW-1]);
      end
      dq_q[0] <= '0;
      dd_q[0] <= {root_q[RW-1], 1'b0};
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_dv
    localparam int B = QB - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dd_q[j]) << B;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dd_q[j+1] <= dd_q[j];
        for (int i = 0; i < 3; i++) begin
          if (dn_q[j][i] >= dsh) begin
            dn_q[j+1][i] <= dn_q[j][i] - dsh;
            dq_q[j+1][i] <= dq_q[j][i] | (QB'(1) << B);
          end else begin
            dn_q[j+1][i] <= dn_q[j][i];
            dq_q[j+1][i] <= dq_q[j][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= ctx_q[P_OUT-1].side;
      for (int i = 0; i < 3; i++) begin
        if (ctx_q[P_OUT-1].fall) begin
          n_q[i] <= ctx_q[P_OUT-1].fb[i];
        end else if (ctx_q[P_OUT-1].neg[i]) begin
          n_q[i] <= -CB'(dq_q[QB][i]);
        end else begin
          n_q[i] <= CB'(dq_q[QB][i]);
        end
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign n_o     = n_q;
  assign side_o  = side_q;

endmodule

FILE: hw/rtl/rnb_reorient.sv
// Reorientation stages: t = base + up, u = flipped detail, scale = t.u,
// rr = t*scale - u*t.z. Four register stages. Depends on rnb_pkg.
`timescale 1ns / 1ps
module rnb_reorient import rnb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  vec_t          base_i,
  input  vec_t          detail_i,
  input  logic [AW-1:0] amount_i,
  output logic          valid_o,
  output nvec_t         rr_o,
  output side_t         side_o
);

  localparam int TW  = CB + 1;
  localparam int SCW = CB + 2;

  typedef logic signed [TW-1:0] tcomp_t;

  tcomp_t                t_d [3];
  tcomp_t                u_d [3];
  tcomp_t                t1_q [3];
  tcomp_t                u1_q [3];
  tcomp_t                t2_q [3];
  tcomp_t                u2_q [3];
  logic signed [PW-1:0]  p_q [3];
  logic signed [SCW-1:0] scale_q;
  logic signed [PW-1:0]  a_q [3];
  logic signed [PW-1:0]  b_q [3];
  nvec_t                 rr_q;
  side_t                 side_q [4];
  logic [3:0]            vld_q;

  always_comb begin
    t_d[0] = TW'($signed(base_i[0]));
    t_d[1] = TW'($signed(base_i[1]));
    t_d[2] = TW'($signed(base_i[2])) + TW'(ONE);
    u_d[0] = -TW'($signed(detail_i[0]));
    u_d[1] = -TW'($signed(detail_i[1]));
    u_d[2] = TW'($signed(detail_i[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].base   <= base_i;
      side_q[0].amount <= amount_i;
      for (int s = 1; s < 4; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        t1_q[i] <= t_d[i];
        u1_q[i] <= u_d[i];
        p_q[i]  <= PW'(t_d[i]) * PW'(u_d[i]);
        t2_q[i] <= t1_q[i];
        u2_q[i] <= u1_q[i];
        a_q[i]  <= PW'(t2_q[i]) * PW'(scale_q);
        b_q[i]  <= PW'(u2_q[i]) * PW'(t2_q[2]);
        rr_q[i] <= VW'(drop_frac(a_q[i]) - drop_frac(b_q[i]));
      end
      scale_q <= SCW'(drop_frac(p_q[0] + p_q[1] + p_q[2]));
    end
  end

  assign valid_o = vld_q[3];
  assign rr_o    = rr_q;
  assign side_o  = side_q[3];

endmodule

FILE: hw/rtl/rnb_lerp.sv
// Blend stages: bl = base + (r - base) * amount, two register stages.
// Depends on rnb_pkg.
`timescale 1ns / 1ps
module rnb_lerp import rnb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  vec_t  r_i,
  input  side_t side_i,
  output logic  valid_o,
  output nvec_t bl_o,
  output vec_t  base_o
);

  logic signed [PW-1:0] m_q [3];
  vec_t                 base1_q;
  vec_t                 base2_q;
  nvec_t                bl_q;
  logic [1:0]           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base1_q <= side_i.base;
      base2_q <= base1_q;
      for (int i = 0; i < 3; i++) begin
        m_q[i]  <= (PW'($signed(r_i[i])) - PW'($signed(side_i.base[i])))
                   * PW'($signed({1'b0, side_i.amount}));
        bl_q[i] <= VW'(PW'($signed(base1_q[i])) + drop_frac(m_q[i]));
      end
    end
  end

  assign valid_o = vld_q[1];
  assign bl_o    = bl_q;
  assign base_o  = base2_q;

endmodule

FILE: hw/rtl/reoriented_normal_blend.sv
// Reoriented normal blend, top level: two normalisers of 57 stages in
// parallel, 4 reorient stages, a 57-stage normaliser, 2 blend stages and a
// final 57-stage normaliser. One item per cycle; the whole pipeline holds
// while a finished item waits at the output register.
// Reset clears all valid bits and sets min_length_squared to 1.
`timescale 1ns / 1ps
module reoriented_normal_blend import rnb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [MLW-1:0] cfg_data_i,
  rnb_in_if.sink         in_i,
  rnb_out_if.source      out_o
);

  logic [MLW-1:0] mls_q;
  logic           en;
  logic [AW-1:0]  amount;
  nvec_t          rv;
  nvec_t          dv;
  vec_t           up;
  side_t          side_in;
  logic           v1;
  vec_t           n1;
  side_t          s1;
  vec_t           n2;
  logic           vr;
  nvec_t          rr;
  side_t          sr;
  logic           v3;
  vec_t           n3;
  side_t          s3;
  logic           vl;
  nvec_t          bl;
  vec_t           bl_base;
  logic           v4;
  vec_t           n4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mls_q <= MLW'(1);
    end else if (cfg_we_i) begin
      mls_q <= cfg_data_i;
    end
  end

  assign en         = !v4 || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    if (in_i.strength[CB-1]) begin
      amount = '0;
    end else if (in_i.strength > CB'(ONE)) begin
      amount = AW'(ONE);
    end else begin
      amount = in_i.strength[AW-1:0];
    end
    rv[0]          = VW'(in_i.receiver_x);
    rv[1]          = VW'(in_i.receiver_y);
    rv[2]          = VW'(in_i.receiver_z);
    dv[0]          = VW'(in_i.detail_x);
    dv[1]          = VW'(in_i.detail_y);
    dv[2]          = VW'(in_i.detail_z);
    up[0]          = '0;
    up[1]          = '0;
    up[2]          = CB'(ONE);
    side_in.base   = '0;
    side_in.amount = amount;
  end

  rnb_norm u_norm_rcv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .v_i(rv), .fb_i(up),
    .side_i(side_in), .mls_i(mls_q), .valid_o(v1), .n_o(n1), .side_o(s1)
  );

  rnb_norm u_norm_dtl (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .v_i(dv), .fb_i(up),
    .side_i('0), .mls_i(mls_q), .valid_o(), .n_o(n2), .side_o()
  );

  rnb_reorient u_reorient (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .base_i(n1), .detail_i(n2),
    .amount_i(s1.amount), .valid_o(vr), .rr_o(rr), .side_o(sr)
  );

  rnb_norm u_norm_rr (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vr), .v_i(rr), .fb_i(sr.base),
    .side_i(sr), .mls_i(mls_q), .valid_o(v3), .n_o(n3), .side_o(s3)
  );

  rnb_lerp u_lerp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3), .r_i(n3), .side_i(s3),
    .valid_o(vl), .bl_o(bl), .base_o(bl_base)
  );

  rnb_norm u_norm_bl (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vl), .v_i(bl), .fb_i(bl_base),
    .side_i('0), .mls_i(mls_q), .valid_o(v4), .n_o(n4), .side_o()
  );

  assign out_o.valid = v4;
  assign out_o.out_x = n4[0];
  assign out_o.out_y = n4[1];
  assign out_o.out_z = n4[2];

endmodule

FILE: hw/rtl/rnb_chk.sv
// Port-level checks for the reoriented normal blend, bound to the top level.
// Depends on rnb_pkg and reoriented_normal_blend.
`timescale 1ns / 1ps
module rnb_chk import rnb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input comp_t       out_x_i,
  input comp_t       out_y_i,
  input comp_t       out_z_i
);

  localparam comp_t LIM = CB'(ONE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i))
    else $error("output item changed while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with output free");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_x_i <= LIM && out_x_i >= -LIM && out_y_i <= LIM &&
                    out_y_i >= -LIM && out_z_i <= LIM && out_z_i >= -LIM)
    else $error("output component beyond unit range");

endmodule

bind reoriented_normal_blend rnb_chk u_rnb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_z_i     (out_o.out_z)
);
